FILE: src/avr_pkg.sv
// ----------------------------------------------------------------------------
// avr_pkg - shared types and constants of the axis vector rotator
// Word layouts of both channels, the front-to-back word, opcodes and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package avr_pkg;

  // Axis codes carried in the opcode field
  localparam logic [1:0] OP_ROT_X = 2'd0;
  localparam logic [1:0] OP_ROT_Y = 2'd1;
  localparam logic [1:0] OP_ROT_Z = 2'd2;
  localparam logic [1:0] OP_PASS  = 2'd3;

  // One full turn in 1/64 degree units
  localparam int TURN_UNITS = 23040;
  // Phase scale: (u * PHASE_MUL) >> 14 maps a turn onto 2^32
  localparam logic [31:0] PHASE_MUL = 32'd3054198966;
  // CORDIC gain compensation in Q2.30
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  // Table length; steps beyond it are not built
  localparam int ATAN_ENTRIES = 30;
  // Depth of the queue between front and back
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] angle;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic signed [31:0] w_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic signed [31:0] w_out;
  } out_word_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic [1:0]         opcode;
    logic               flip;
    logic signed [31:0] phase;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } phase_word_t;

  // atan(2^-i) in binary phase units (2^32 per turn)
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'd536870912;
      5'd1:  val = 32'd316933406;
      5'd2:  val = 32'd167458907;
      5'd3:  val = 32'd85004756;
      5'd4:  val = 32'd42667331;
      5'd5:  val = 32'd21354465;
      5'd6:  val = 32'd10679838;
      5'd7:  val = 32'd5340245;
      5'd8:  val = 32'd2670163;
      5'd9:  val = 32'd1335087;
      5'd10: val = 32'd667544;
      5'd11: val = 32'd333772;
      5'd12: val = 32'd166886;
      5'd13: val = 32'd83443;
      5'd14: val = 32'd41722;
      5'd15: val = 32'd20861;
      5'd16: val = 32'd10430;
      5'd17: val = 32'd5215;
      5'd18: val = 32'd2608;
      5'd19: val = 32'd1304;
      5'd20: val = 32'd652;
      5'd21: val = 32'd326;
      5'd22: val = 32'd163;
      5'd23: val = 32'd81;
      5'd24: val = 32'd41;
      5'd25: val = 32'd20;
      5'd26: val = 32'd10;
      5'd27: val = 32'd5;
      5'd28: val = 32'd3;
      5'd29: val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

FILE: src/avr_front.sv
// ----------------------------------------------------------------------------
// avr_front - angle reduction and phase classification
// Two stages: reduce the angle modulo one turn, then scale it to a binary
// phase and fold it into [-90, 90) degrees.
// ----------------------------------------------------------------------------
module avr_front
  import avr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  in_word_t    word_i,
  output logic        stall_o,
  input  logic        full_i,
  output logic        push_o,
  output phase_word_t word_o
);

  typedef struct packed {
    logic [1:0]         opcode;
    logic [14:0]        turn;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } red_t;

  logic               f1_v_q, f2_v_q;
  logic               adv;
  red_t               f1_d, f1_q;
  phase_word_t        f2_d, f2_q;
  logic signed [16:0] ang_ext;
  logic signed [16:0] ang_red;
  logic [46:0]        prod;
  logic [31:0]        ph;
  logic               flip;

  // Hold both stages only while the second one cannot hand over its word
  assign adv     = !(f2_v_q && full_i);
  assign stall_o = !adv;
  assign push_o  = f2_v_q && !full_i;
  assign word_o  = f2_q;

  // Reduce into [0, TURN_UNITS)
  always_comb begin
    ang_ext = 17'(word_i.angle);
    if (ang_ext < -17'(TURN_UNITS)) begin
      ang_red = ang_ext + 17'(2 * TURN_UNITS);
    end else if (ang_ext < 17'sd0) begin
      ang_red = ang_ext + 17'(TURN_UNITS);
    end else if (ang_ext >= 17'(TURN_UNITS)) begin
      ang_red = ang_ext - 17'(TURN_UNITS);
    end else begin
      ang_red = ang_ext;
    end
    f1_d = '{opcode: word_i.opcode, turn: ang_red[14:0], x: word_i.x_in,
             y: word_i.y_in, z: word_i.z_in, w: word_i.w_in};
  end

  // Scale to phase, fold the second and third quadrants
  always_comb begin
    prod = 47'(f1_q.turn) * 47'(PHASE_MUL);
    ph   = prod[45:14];
    flip = ph[31] ^ ph[30];
    f2_d = '{opcode: f1_q.opcode, flip: flip,
             phase: {ph[31] ^ flip, ph[30:0]},
             x: f1_q.x, y: f1_q.y, z: f1_q.z, w: f1_q.w};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (adv) begin
      f1_v_q <= valid_i;
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_q <= f1_d;
      f2_q <= f2_d;
    end
  end

endmodule

FILE: src/avr_fifo.sv
// ----------------------------------------------------------------------------
// avr_fifo - queue between front and back
// Small circular buffer with a registered read port that feeds the back.
// ----------------------------------------------------------------------------
module avr_fifo
  import avr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  phase_word_t data_i,
  output logic        full_o,
  input  logic        adv_i,
  output logic        valid_o,
  output phase_word_t data_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  phase_word_t      mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  logic             rd_v_q;
  phase_word_t      rd_q;

  assign pop     = adv_i && (cnt_q != '0);
  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = rd_v_q;
  assign data_o  = rd_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      rd_v_q   <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (adv_i) begin
        rd_v_q <= pop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
    if (pop) begin
      rd_q <= mem[rd_ptr_q];
    end
  end

endmodule

FILE: src/avr_back.sv
// ----------------------------------------------------------------------------
// avr_back - CORDIC pipeline and rotation datapath
// One CORDIC micro-rotation per stage, then operand select, four products,
// the two sums, and rounding with saturation into the output register.
// ----------------------------------------------------------------------------
module avr_back
  import avr_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
)
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  phase_word_t word_i,
  output logic        valid_o,
  output out_word_t   word_o
);

  localparam int unsigned NS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               flip;
    logic signed [31:0] res;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } cstage_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } sel_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [63:0] ac;
    logic signed [63:0] bs;
    logic signed [63:0] as_p;
    logic signed [63:0] bc;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } mul_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [64:0] p;
    logic signed [64:0] q;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } sum_t;

  // Round Q46 to Q16, optionally negate, clamp to 32 bits
  function automatic logic [31:0] round_sat(input logic signed [64:0] v, input logic neg);
    logic signed [65:0] biased;
    logic signed [35:0] shifted;
    logic signed [36:0] signed_v;
    logic [31:0]        res;
    biased   = 66'(v) + 66'sd536870912;
    shifted  = biased[65:30];
    signed_v = neg ? -37'(shifted) : 37'(shifted);
    if (signed_v > 37'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (signed_v < -37'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = signed_v[31:0];
    end
    return res;
  endfunction

  cstage_t        cin   [NS];
  cstage_t        cst_q [NS];
  logic [NS-1:0]  cv_q;
  sel_t           sel_d, sel_q;
  mul_t           mul_d, mul_q;
  sum_t           sum_d, sum_q;
  out_word_t      out_d, out_q;
  logic [3:0]     pv_q;
  logic [31:0]    rp, rq;

  // Seed the first micro-rotation from the queue output
  assign cin[0] = '{opcode: word_i.opcode, flip: word_i.flip, res: word_i.phase,
                    cx: CORDIC_GAIN, cy: 32'sd0,
                    x: word_i.x, y: word_i.y, z: word_i.z, w: word_i.w};

  for (genvar k = 0; k < NS; k++) begin : g_step
    cstage_t            cnx;
    logic signed [31:0] dx, dy;
    if (k > 0) begin : g_link
      assign cin[k] = cst_q[k-1];
    end
    assign dx = $signed(cin[k].cy) >>> k;
    assign dy = $signed(cin[k].cx) >>> k;
    always_comb begin
      cnx = cin[k];
      if (!cin[k].res[31]) begin
        cnx.cx  = cin[k].cx - dx;
        cnx.cy  = cin[k].cy + dy;
        cnx.res = cin[k].res - $signed(atan_entry(5'(k)));
      end else begin
        cnx.cx  = cin[k].cx + dx;
        cnx.cy  = cin[k].cy - dy;
        cnx.res = cin[k].res + $signed(atan_entry(5'(k)));
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        cst_q[k] <= cnx;
      end
    end
  end

  // Undo the fold and pick the rotated pair
  always_comb begin
    sel_d.opcode = cst_q[NS-1].opcode;
    sel_d.c      = cst_q[NS-1].flip ? -cst_q[NS-1].cx : cst_q[NS-1].cx;
    sel_d.s      = cst_q[NS-1].flip ? -cst_q[NS-1].cy : cst_q[NS-1].cy;
    sel_d.x      = cst_q[NS-1].x;
    sel_d.y      = cst_q[NS-1].y;
    sel_d.z      = cst_q[NS-1].z;
    sel_d.w      = cst_q[NS-1].w;
    unique case (cst_q[NS-1].opcode)
      OP_ROT_X: begin
        sel_d.a = cst_q[NS-1].z;
        sel_d.b = cst_q[NS-1].y;
      end
      OP_ROT_Y: begin
        sel_d.a = cst_q[NS-1].x;
        sel_d.b = cst_q[NS-1].z;
      end
      default: begin
        sel_d.a = cst_q[NS-1].x;
        sel_d.b = cst_q[NS-1].y;
      end
    endcase
  end

  always_comb begin
    mul_d.opcode = sel_q.opcode;
    mul_d.ac     = 64'(sel_q.a) * 64'(sel_q.c);
    mul_d.bs     = 64'(sel_q.b) * 64'(sel_q.s);
    mul_d.as_p   = 64'(sel_q.a) * 64'(sel_q.s);
    mul_d.bc     = 64'(sel_q.b) * 64'(sel_q.c);
    mul_d.x      = sel_q.x;
    mul_d.y      = sel_q.y;
    mul_d.z      = sel_q.z;
    mul_d.w      = sel_q.w;
  end

  always_comb begin
    sum_d.opcode = mul_q.opcode;
    sum_d.p      = 65'(mul_q.ac) - 65'(mul_q.bs);
    sum_d.q      = 65'(mul_q.as_p) + 65'(mul_q.bc);
    sum_d.x      = mul_q.x;
    sum_d.y      = mul_q.y;
    sum_d.z      = mul_q.z;
    sum_d.w      = mul_q.w;
  end

  // Round, saturate and put the pair back in place
  always_comb begin
    rp = round_sat(sum_q.p, 1'b0);
    rq = round_sat(sum_q.q, sum_q.opcode == OP_ROT_Z);
    out_d = '{x_out: sum_q.x, y_out: sum_q.y, z_out: sum_q.z, w_out: sum_q.w};
    unique case (sum_q.opcode)
      OP_ROT_X: begin
        out_d.z_out = rp;
        out_d.y_out = rq;
      end
      OP_ROT_Y: begin
        out_d.x_out = rp;
        out_d.z_out = rq;
      end
      OP_ROT_Z: begin
        out_d.x_out = rp;
        out_d.y_out = rq;
      end
      default: begin
        out_d.x_out = sum_q.x;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
      pv_q <= '0;
    end else if (adv_i) begin
      cv_q <= {cv_q[NS-2:0], valid_i};
      pv_q <= {pv_q[2:0], cv_q[NS-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sel_q <= sel_d;
      mul_q <= mul_d;
      sum_q <= sum_d;
      out_q <= out_d;
    end
  end

  assign valid_o = pv_q[3];
  assign word_o  = out_q;

endmodule

FILE: src/axis_vector_rotator.sv
// ----------------------------------------------------------------------------
// axis_vector_rotator - rotate a four-component vector about one axis
// Top level: front angle classifier, queue, CORDIC back end.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one word per cycle: opcode (axis), angle in 1/64
//   degree and a Q16.16 vector. The m_ channel returns one word per input
//   word, in order: the vector rotated about the chosen axis, rounded and
//   saturated; w always passes through, and opcode three passes all four.
//   A word is taken at a clock edge where valid is high and stall is low.
//   From acceptance to m_valid_o a word passes two front stages, a queue
//   write and a registered read, one stage per CORDIC micro-rotation,
//   then select, multiply, sum and the output register. Throughput is one
//   word per cycle while no stall is raised, set by the fully pipelined
//   CORDIC and product stages. When m_stall_i is held while a word is
//   offered, the back end freezes and the output word holds; the front
//   keeps taking words until its queue of FIFO_DEPTH entries is full, then
//   raises s_stall_o. After a long stall, no input word is taken in the
//   release cycle while the full flag clears.
//   Reset (rst_ni low, asynchronous) empties the queue and clears every
//   valid flag; words in flight are dropped and none is produced across it.
// ----------------------------------------------------------------------------
module axis_vector_rotator
  import avr_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
)
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_stall_o,
  input  in_word_t  s_word_i,
  output logic      m_valid_o,
  input  logic      m_stall_i,
  output out_word_t m_word_o
);

  logic        push;
  logic        full;
  logic        back_adv;
  logic        q_valid;
  phase_word_t front_word;
  phase_word_t q_word;

  // Advance the whole back end unless a finished word is waiting
  assign back_adv = !(m_valid_o && m_stall_i);

  avr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid_i),
    .word_i  (s_word_i),
    .stall_o (s_stall_o),
    .full_i  (full),
    .push_o  (push),
    .word_o  (front_word)
  );

  avr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_word),
    .full_o  (full),
    .adv_i   (back_adv),
    .valid_o (q_valid),
    .data_o  (q_word)
  );

  avr_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (back_adv),
    .valid_i (q_valid),
    .word_i  (q_word),
    .valid_o (m_valid_o),
    .word_o  (m_word_o)
  );

endmodule

FILE: src/avr_checker.sv
// ----------------------------------------------------------------------------
// avr_checker - port-level checks for the axis vector rotator
// Watches the two channels and reset, attached to the top level by bind.
// ----------------------------------------------------------------------------
module avr_checker
  import avr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      s_valid_i,
  input logic      s_stall_o,
  input in_word_t  s_word_i,
  input logic      m_valid_o,
  input logic      m_stall_i,
  input out_word_t m_word_o
);

  // Keep an offered result offered while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && m_stall_i |=> m_valid_o)
    else $error("result dropped while stalled");

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && m_stall_i |=> $stable(m_word_o))
    else $error("stalled result word changed");

  // Reset leaves nothing offered and nothing blocked from the next edge on
  assert property (@(posedge clk_i)
    !rst_ni |=> !m_valid_o && !s_stall_o)
    else $error("channel active during reset");

  // The input side only backs up behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_stall_o |-> m_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind axis_vector_rotator avr_checker u_avr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_valid_i (s_valid_i),
  .s_stall_o (s_stall_o),
  .s_word_i  (s_word_i),
  .m_valid_o (m_valid_o),
  .m_stall_i (m_stall_i),
  .m_word_o  (m_word_o)
);

FILE: dv/axis_vector_rotator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_vector_rotator_tb - self-checking bench for the axis vector rotator
// Streams axis, angle and vector words through the block under random input
// gaps and output back pressure. Every returned word is checked against a
// local bit-exact model of the angle reduction, the CORDIC, rounding and
// clamping.
// ----------------------------------------------------------------------------
module axis_vector_rotator_tb;
  import avr_pkg::*;

  // Must match the parameter handed to the instance below
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned TABLE_LEN    = 30;
  // Model constants: one turn in 1/64 degree, turn-to-phase scale, CORDIC gain
  localparam longint      DEG64_TURN    = 23040;
  localparam logic [63:0] TURN_TO_PHASE = 64'd3054198966;
  localparam longint      GAIN_Q30      = 64'sd652032874;
  localparam longint      ROUND_HALF    = 64'sd536870912;
  // Settle time after the last expected word
  localparam int          DRAIN_CYCLES  = CORDIC_STEPS + 20;
  localparam int          MAX_REPORTS   = 10;

  localparam logic signed [15:0] DEG_90  = 16'sd5760;
  localparam logic signed [15:0] DEG_45  = 16'sd2880;
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] NEG_MAX = 32'sh8000_0000;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      s_valid_i = 1'b0;
  logic      s_stall_o;
  in_word_t  s_word_i  = '0;
  logic      m_valid_o;
  logic      m_stall_i = 1'b0;
  out_word_t m_word_o;

  // atan(2^-i) in phase units, 2^32 per turn
  longint arctan_q32 [TABLE_LEN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81, 41,
    20, 10, 5, 3, 1
  };

  // Rotated words still owed by the block, oldest first
  out_word_t rotated_q [$];

  bit idle_en      = 1'b1;
  int mismatch_cnt = 0;
  int checked_cnt  = 0;
  int clamp_cnt    = 0;
  int sent_per_op [4] = '{0, 0, 0, 0};

  axis_vector_rotator #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_valid_i),
    .s_stall_o(s_stall_o),
    .s_word_i (s_word_i),
    .m_valid_o(m_valid_o),
    .m_stall_i(m_stall_i),
    .m_word_o (m_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Round a Q16.16 x Q30 sum to Q16.16 (floor of value plus half), optionally
  // negate, then clamp to 32 bits; count every clamp.
  function automatic logic signed [31:0] round_clamp(input longint acc, input bit negate,
                                                    inout int clamps);
    longint t;
    t = (acc + ROUND_HALF) >>> 30;
    if (negate) t = -t;
    if (t > longint'(POS_MAX)) begin
      t = longint'(POS_MAX);
      clamps++;
    end else if (t < longint'(NEG_MAX)) begin
      t = longint'(NEG_MAX);
      clamps++;
    end
    return t[31:0];
  endfunction

  // Full bit-exact rotation of one input word
  function automatic out_word_t rotate_vector(input in_word_t w, output int clamps);
    longint      turn_pos, resid, cx, cy, dx, dy, c, s, vx, vy, vz;
    logic [63:0] wide;
    logic [31:0] ph;
    bit          flip;
    int unsigned i;
    out_word_t   r;

    clamps = 0;
    vx = longint'($signed(w.x_in));
    vy = longint'($signed(w.y_in));
    vz = longint'($signed(w.z_in));
    r.x_out = w.x_in;
    r.y_out = w.y_in;
    r.z_out = w.z_in;
    r.w_out = w.w_in;

    // Reduce the angle to one turn and scale it onto a 32-bit phase
    turn_pos = longint'($signed(w.angle)) % DEG64_TURN;
    if (turn_pos < 0) turn_pos += DEG64_TURN;
    wide = turn_pos;
    wide = wide * TURN_TO_PHASE;
    ph   = wide[45:14];

    // Fold the second and third quadrants by half a turn, negate at the end
    flip = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
    if (flip) ph = ph + 32'h8000_0000;
    resid = longint'($signed(ph));

    cx = GAIN_Q30;
    cy = 0;
    for (i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (resid >= 0) begin
        cx    -= dx;
        cy    += dy;
        resid -= arctan_q32[i];
      end else begin
        cx    += dx;
        cy    -= dy;
        resid += arctan_q32[i];
      end
    end
    c = flip ? -cx : cx;
    s = flip ? -cy : cy;

    case (w.opcode)
      OP_ROT_X: begin
        r.z_out = round_clamp(vz * c - vy * s, 1'b0, clamps);
        r.y_out = round_clamp(vz * s + vy * c, 1'b0, clamps);
      end
      OP_ROT_Y: begin
        r.x_out = round_clamp(vx * c - vz * s, 1'b0, clamps);
        r.z_out = round_clamp(vx * s + vz * c, 1'b0, clamps);
      end
      OP_ROT_Z: begin
        // The new y comes out negated
        r.x_out = round_clamp(vx * c - vy * s, 1'b0, clamps);
        r.y_out = round_clamp(vx * s + vy * c, 1'b1, clamps);
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic in_word_t make_word(input logic [1:0] op, input logic signed [15:0] ang,
                                         input logic signed [31:0] x, input logic signed [31:0] y,
                                         input logic signed [31:0] z, input logic signed [31:0] w);
    in_word_t v;
    v.opcode = op;
    v.angle  = ang;
    v.x_in   = x;
    v.y_in   = y;
    v.z_in   = z;
    v.w_in   = w;
    return v;
  endfunction

  // Mix full-range values with rail values and small Q16.16 magnitudes
  function automatic logic signed [31:0] rand_component();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = POS_MAX;
          1:       v = NEG_MAX;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2:    v = 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Mostly any angle; a quarter land on or next to a multiple of 90 degrees
  function automatic logic signed [15:0] rand_angle();
    int k;
    if ($urandom_range(0, 3) == 0) begin
      k = int'($urandom_range(0, 10)) - 5;
      return 16'(k * 5760 + int'($urandom_range(0, 2)) - 1);
    end
    return 16'($urandom);
  endfunction

  function automatic in_word_t rand_word();
    logic [1:0] op;
    op = ($urandom_range(0, 9) == 0) ? OP_PASS : 2'($urandom_range(0, 2));
    return make_word(op, rand_angle(), rand_component(), rand_component(),
                     rand_component(), rand_component());
  endfunction

  // Offer one word, hold it until taken, then log the rotation it must give.
  // Valid stays high on exit; a gap in the next call or the end of the run drops it.
  task automatic send_vector(input in_word_t w);
    out_word_t   want;
    int          clamps;
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      repeat (gap) begin
        @(negedge clk_i);
        s_valid_i <= 1'b0;
        s_word_i  <= rand_word();
      end
    end
    @(negedge clk_i);
    s_valid_i <= 1'b1;
    s_word_i  <= w;
    @(posedge clk_i);
    while (s_stall_o) @(posedge clk_i);
    want = rotate_vector(w, clamps);
    rotated_q.push_back(want);
    clamp_cnt += clamps;
    sent_per_op[w.opcode]++;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("[%0t] word %0d: %s expected %08h, got %08h", $realtime, checked_cnt, what,
               want, got);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Each axis at 0, 90, 180 and -90 degrees
  task automatic test_axis_quadrants();
    logic [1:0]         axes [3] = '{OP_ROT_X, OP_ROT_Y, OP_ROT_Z};
    logic signed [15:0] angs [4] = '{16'sd0, DEG_90, 16'sd11520, -DEG_90};
    foreach (axes[a])
      foreach (angs[k])
        send_vector(make_word(axes[a], angs[k], ONE_Q16, -2 * ONE_Q16, 3 * ONE_Q16,
                              32'sh0000_8000));
  endtask

  // Angle field rails, a whole turn each way, and just short of a quadrant edge
  task automatic test_angle_extremes();
    send_vector(make_word(OP_ROT_X, 16'sh7fff, POS_MAX, ONE_Q16, NEG_MAX, NEG_MAX));
    send_vector(make_word(OP_ROT_Y, 16'sh8000, NEG_MAX, POS_MAX, ONE_Q16, POS_MAX));
    send_vector(make_word(OP_ROT_Z, 16'sd23040, ONE_Q16, POS_MAX, '0, '1));
    send_vector(make_word(OP_ROT_X, -16'sd23040, '1, ONE_Q16, -ONE_Q16, '0));
    send_vector(make_word(OP_ROT_Y, DEG_90 - 16'sd1, -ONE_Q16, '0, 5 * ONE_Q16, ONE_Q16));
  endtask

  // Push results over both rails, including the negated y about Z
  task automatic test_clamping();
    send_vector(make_word(OP_ROT_X, DEG_45, POS_MAX, NEG_MAX, POS_MAX, '0));
    send_vector(make_word(OP_ROT_Y, DEG_45, POS_MAX, '0, POS_MAX, '1));
    send_vector(make_word(OP_ROT_Z, DEG_45, NEG_MAX, NEG_MAX, '0, ONE_Q16));
    send_vector(make_word(OP_ROT_Z, 16'sd0, ONE_Q16, NEG_MAX, '0, '0));
    send_vector(make_word(OP_ROT_X, -DEG_45, '0, NEG_MAX, NEG_MAX, POS_MAX));
  endtask

  // Opcode three leaves all four components alone
  task automatic test_pass_opcode();
    send_vector(make_word(OP_PASS, DEG_45, POS_MAX, NEG_MAX, '1, ONE_Q16));
    send_vector(make_word(OP_PASS, 16'sh8000, NEG_MAX, POS_MAX, '0, NEG_MAX));
  endtask

  task automatic test_random_traffic(input int n);
    repeat (n) send_vector(rand_word());
  endtask

  // Back-to-back words with no gaps and no back pressure
  task automatic test_steady_stream(input int n);
    idle_en = 1'b0;
    repeat (n) send_vector(rand_word());
  endtask

  // --------------------------------------------------------------------------
  // Output back pressure: random stall bursts between free runs
  // --------------------------------------------------------------------------
  initial begin : drive_out_stall
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 14);
        repeat (n) begin
          @(negedge clk_i);
          m_stall_i <= 1'b1;
        end
      end else begin
        n = $urandom_range(1, 30);
        repeat (n) begin
          @(negedge clk_i);
          m_stall_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each word taken with the oldest rotation owed
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_rotations
    out_word_t want;
    if (rst_ni && m_valid_o && !m_stall_i) begin
      if (rotated_q.size() == 0) begin
        note_mismatch("unexpected word, x_out", '0, m_word_o.x_out);
      end else begin
        want = rotated_q.pop_front();
        if (m_word_o.x_out !== want.x_out) note_mismatch("x_out", want.x_out, m_word_o.x_out);
        if (m_word_o.y_out !== want.y_out) note_mismatch("y_out", want.y_out, m_word_o.y_out);
        if (m_word_o.z_out !== want.z_out) note_mismatch("z_out", want.z_out, m_word_o.z_out);
        if (m_word_o.w_out !== want.w_out) note_mismatch("w_out", want.w_out, m_word_o.w_out);
      end
      checked_cnt++;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed words, random traffic, steady stream, drain
  // --------------------------------------------------------------------------
  initial begin : run_tests
    int guard;
    // Hold reset, then release it away from the rising edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_axis_quadrants();
    test_angle_extremes();
    test_clamping();
    test_pass_opcode();
    test_random_traffic(1400);
    test_steady_stream(100);

    // Drop valid once the last word has been taken
    @(negedge clk_i);
    s_valid_i <= 1'b0;

    guard = 0;
    while (rotated_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    // Allow any stray word to surface
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (rotated_q.size() != 0) begin
      mismatch_cnt += rotated_q.size();
      $display("%0d expected words never returned", rotated_q.size());
    end

    $display("Sent %0d words: about X %0d, about Y %0d, about Z %0d, pass-through %0d.",
             sent_per_op[0] + sent_per_op[1] + sent_per_op[2] + sent_per_op[3],
             sent_per_op[OP_ROT_X], sent_per_op[OP_ROT_Y], sent_per_op[OP_ROT_Z],
             sent_per_op[OP_PASS]);
    $display("Checked %0d result words, %0d clamped components, %0d mismatches.",
             checked_cnt, clamp_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5000000;
    $display("Timeout with %0d words outstanding", rotated_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
